// ----- rtl/lde_pkg.sv -----
// shared types and constants for the line table delta encoder
// no dependencies; used by every module under rtl

package lde_pkg;

  localparam int unsigned ADDR_W          = 64;
  localparam int unsigned LINE_W          = 32;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned CMD_QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] OP_END_EXT      = 8'd0;
  localparam logic [BYTE_W-1:0] OP_COPY         = 8'd1;
  localparam logic [BYTE_W-1:0] OP_ADVANCE_PC   = 8'd2;
  localparam logic [BYTE_W-1:0] OP_ADVANCE_LINE = 8'd3;
  localparam logic [BYTE_W-1:0] EXT_LEN_ONE     = 8'd1;
  localparam logic [BYTE_W-1:0] EXT_END_SEQ     = 8'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [LINE_W-1:0] source_line;
    logic              end_of_sequence;
    logic              restart;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } out_item_t;

  // one classified row, as handed from the front part to the back part
  typedef struct packed {
    logic [ADDR_W-1:0] addr_delta;
    logic              addr_chg;
    logic [LINE_W-1:0] line_diff;
    logic              line_chg;
    logic              end_seq;
  } cmd_t;

endpackage

// ----- rtl/line_table_delta_encoder.sv -----
// top level of the line table delta encoder: front, command queue, back
// depends on lde_pkg, lde_front, lde_cmd_queue, lde_back
//
//   channel   ports                          direction  moves
//   input     in_push, in_full, in_item      in         one line-table row per request
//   result    out_empty, out_pop, out_item   out        one program byte per request
//
// a row of n bytes (1 to 21) passes the back part as follows: the row is first loaded from
// the command queue, then the leb128 sequencer gives one byte per cycle unless out_pop holds it.
// the front part takes one row per cycle until the command queue (QueueDepth rows) fills.
// synchronous reset sets previous address to 0 and previous line to 1 and empties all queues.
// while out_pop is low the waiting byte holds and the sequencer stalls on it.

module line_table_delta_encoder #(
  parameter int unsigned QueueDepth = lde_pkg::CMD_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  lde_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output lde_pkg::out_item_t out_item
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  lde_pkg::cmd_t q_push_cmd;
  lde_pkg::cmd_t q_pop_cmd;

  lde_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_push_cmd)
  );

  lde_cmd_queue #(
    .Depth (QueueDepth)
  ) u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .empty    (q_empty)
  );

  lde_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_pop_cmd),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ----- rtl/lde_front.sv -----
// front part: accepts rows, forms address and line deltas, keeps previous values
// depends on lde_pkg

module lde_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  lde_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              q_push,
  output lde_pkg::cmd_t     q_cmd
);

  logic [lde_pkg::ADDR_W-1:0] prev_addr_r;
  logic [lde_pkg::ADDR_W-1:0] prev_addr_nxt;
  logic [lde_pkg::LINE_W-1:0] prev_line_r;
  logic [lde_pkg::LINE_W-1:0] prev_line_nxt;
  logic [lde_pkg::ADDR_W-1:0] base_addr;
  logic [lde_pkg::LINE_W-1:0] base_line;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  // restart takes effect before the deltas are formed
  assign base_addr = in_item.restart ? '0 : prev_addr_r;
  assign base_line = in_item.restart ? lde_pkg::LINE_W'(1) : prev_line_r;

  always_comb begin
    q_cmd.addr_delta = in_item.address - base_addr;
    q_cmd.addr_chg   = in_item.address != base_addr;
    q_cmd.line_diff  = in_item.source_line - base_line;
    q_cmd.line_chg   = in_item.source_line != base_line;
    q_cmd.end_seq    = in_item.end_of_sequence;
  end

  assign prev_addr_nxt = q_push ? in_item.address : prev_addr_r;
  assign prev_line_nxt = q_push ? in_item.source_line : prev_line_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_addr_r <= '0;
      prev_line_r <= lde_pkg::LINE_W'(1);
    end else begin
      prev_addr_r <= prev_addr_nxt;
      prev_line_r <= prev_line_nxt;
    end
  end

  a_prev_addr_follows: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> prev_addr_r == $past(in_item.address))
    else $error("previous address not taken from accepted row");

  a_prev_line_follows: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> prev_line_r == $past(in_item.source_line))
    else $error("previous line not taken from accepted row");

endmodule

// ----- rtl/lde_cmd_queue.sv -----
// short queue of classified rows between the front and back parts
// depends on lde_pkg

module lde_cmd_queue #(
  parameter int unsigned Depth = lde_pkg::CMD_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lde_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output lde_pkg::cmd_t pop_cmd,
  output logic          empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  lde_pkg::cmd_t   slot_r [Depth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r;
  logic [PtrW-1:0] rd_ptr_nxt;
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = count_r == FullCnt;
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FullCnt)
    else $error("queue count beyond depth");

endmodule

// ----- rtl/lde_back.sv -----
// back part: turns one classified row into opcode and leb128 bytes, one per cycle
// unless a held byte stalls; depends on lde_pkg; feeds a single output register

module lde_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  lde_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output lde_pkg::out_item_t out_item
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_PC_OP  = 9'b000000010,
    S_PC_DIG = 9'b000000100,
    S_LN_OP  = 9'b000001000,
    S_LN_DIG = 9'b000010000,
    S_COPY   = 9'b000100000,
    S_END0   = 9'b001000000,
    S_END1   = 9'b010000000,
    S_END2   = 9'b100000000
  } state_t;

  state_t                            state_r;
  state_t                            state_nxt;
  logic [lde_pkg::ADDR_W-1:0]        addr_r;
  logic [lde_pkg::ADDR_W-1:0]        addr_nxt;
  logic signed [lde_pkg::LINE_W-1:0] line_r;
  logic signed [lde_pkg::LINE_W-1:0] line_nxt;
  logic                              line_chg_r;
  logic                              line_chg_nxt;
  logic                              end_r;
  logic                              end_nxt;
  lde_pkg::out_item_t                out_r;
  logic                              out_vld_r;
  logic                              out_vld_nxt;
  logic                              step;
  logic [lde_pkg::BYTE_W-1:0]        byte_c;
  logic                              last_c;
  logic [lde_pkg::ADDR_W-1:0]        uleb_rest;
  logic                              uleb_more;
  logic signed [lde_pkg::LINE_W-1:0] sleb_rest;
  logic                              sleb_done;

  assign out_empty = !out_vld_r;
  assign out_item  = out_r;

  // a byte may be produced when the output register is free or being emptied
  assign step = (state_r != S_IDLE) && (!out_vld_r || out_pop);

  assign uleb_rest = addr_r >> 7;
  assign uleb_more = |uleb_rest;
  assign sleb_rest = line_r >>> 7;
  assign sleb_done = ((sleb_rest == '0) && !line_r[6]) || ((sleb_rest == '1) && line_r[6]);

  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    line_nxt     = line_r;
    line_chg_nxt = line_chg_r;
    end_nxt      = end_r;
    q_pop        = 1'b0;
    byte_c       = lde_pkg::OP_COPY;
    last_c       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop        = 1'b1;
          addr_nxt     = q_cmd.addr_delta;
          line_nxt     = q_cmd.line_diff;
          line_chg_nxt = q_cmd.line_chg;
          end_nxt      = q_cmd.end_seq;
          if (q_cmd.addr_chg) begin
            state_nxt = S_PC_OP;
          end else if (q_cmd.line_chg) begin
            state_nxt = S_LN_OP;
          end else begin
            state_nxt = S_COPY;
          end
        end
      end
      S_PC_OP: begin
        byte_c = lde_pkg::OP_ADVANCE_PC;
        if (step) begin
          state_nxt = S_PC_DIG;
        end
      end
      S_PC_DIG: begin
        byte_c = {uleb_more, addr_r[6:0]};
        if (step) begin
          addr_nxt = uleb_rest;
          if (!uleb_more) begin
            state_nxt = line_chg_r ? S_LN_OP : S_COPY;
          end
        end
      end
      S_LN_OP: begin
        byte_c = lde_pkg::OP_ADVANCE_LINE;
        if (step) begin
          state_nxt = S_LN_DIG;
        end
      end
      S_LN_DIG: begin
        byte_c = {!sleb_done, line_r[6:0]};
        if (step) begin
          line_nxt = sleb_rest;
          if (sleb_done) begin
            state_nxt = S_COPY;
          end
        end
      end
      S_COPY: begin
        byte_c = lde_pkg::OP_COPY;
        last_c = !end_r;
        if (step) begin
          state_nxt = end_r ? S_END0 : S_IDLE;
        end
      end
      S_END0: begin
        byte_c = lde_pkg::OP_END_EXT;
        if (step) begin
          state_nxt = S_END1;
        end
      end
      S_END1: begin
        byte_c = lde_pkg::EXT_LEN_ONE;
        if (step) begin
          state_nxt = S_END2;
        end
      end
      S_END2: begin
        byte_c = lde_pkg::EXT_END_SEQ;
        last_c = 1'b1;
        if (step) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (step) begin
      out_vld_nxt = 1'b1;
    end else if (out_pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    line_r     <= line_nxt;
    line_chg_r <= line_chg_nxt;
    end_r      <= end_nxt;
    if (step) begin
      out_r.out_byte <= byte_c;
      out_r.last     <= last_c;
    end
  end

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE) && !q_empty)
    else $error("row taken while another is in progress");

  a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    (step && last_c) |=> state_r == S_IDLE)
    else $error("bytes still produced after final byte of row");

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for line_table_delta_encoder: rows in, program bytes out
// depends on lde_pkg and the rtl under rtl/; byte stream predicted in-bench
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned RANDOM_ROWS = 500;
  localparam int unsigned LIMIT       = 200000;
  localparam int unsigned DRAIN       = 40;
  localparam int unsigned HOLD_AT     = 800;
  localparam int unsigned HOLD_LEN    = 400;
  localparam int unsigned CALM_FROM   = 2500;
  localparam int unsigned CALM_TO     = 3500;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  lde_pkg::in_item_t  in_item = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  lde_pkg::out_item_t out_item;

  lde_pkg::in_item_t  rows_to_send[$];
  lde_pkg::out_item_t program_bytes[$];
  logic [63:0] last_addr = 64'd0;
  logic [31:0] last_line = 32'd1;
  int unsigned rows_total = 0;
  int unsigned rows_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycle = 0;
  int unsigned hold_left = 0;
  logic        calm;

  line_table_delta_encoder uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  assign calm = (cycle >= CALM_FROM) && (cycle < CALM_TO);

  // predicted bytes of one row, updating the previous address and line
  task automatic encode_row(input lde_pkg::in_item_t row);
    logic [7:0]         row_bytes[$];
    logic [7:0]         next_byte;
    lde_pkg::out_item_t entry;
    logic [63:0]        addr_delta;
    logic signed [31:0] line_diff;
    logic [6:0]         chunk;
    logic               done;
    if (row.restart) begin
      last_addr = 64'd0;
      last_line = 32'd1;
    end
    if (row.address != last_addr) begin
      row_bytes = {row_bytes, lde_pkg::OP_ADVANCE_PC};
      addr_delta = row.address - last_addr;
      do begin
        chunk = addr_delta[6:0];
        addr_delta = addr_delta >> 7;
        next_byte = {addr_delta != 64'd0, chunk};
        row_bytes = {row_bytes, next_byte};
      end while (addr_delta != 64'd0);
      last_addr = row.address;
    end
    if (row.source_line != last_line) begin
      row_bytes = {row_bytes, lde_pkg::OP_ADVANCE_LINE};
      line_diff = signed'(row.source_line - last_line);
      do begin
        chunk = line_diff[6:0];
        line_diff = line_diff >>> 7;
        done = (line_diff == 0 && !chunk[6]) || (line_diff == -1 && chunk[6]);
        next_byte = {!done, chunk};
        row_bytes = {row_bytes, next_byte};
      end while (!done);
      last_line = row.source_line;
    end
    row_bytes = {row_bytes, lde_pkg::OP_COPY};
    if (row.end_of_sequence) begin
      row_bytes = {row_bytes, lde_pkg::OP_END_EXT};
      row_bytes = {row_bytes, lde_pkg::EXT_LEN_ONE};
      row_bytes = {row_bytes, lde_pkg::EXT_END_SEQ};
    end
    foreach (row_bytes[i]) begin
      entry.out_byte = row_bytes[i];
      entry.last     = (i == row_bytes.size() - 1);
      program_bytes  = {program_bytes, entry};
    end
  endtask

  task automatic add_row(input logic [63:0] addr, input logic [31:0] line,
                         input logic eos, input logic rst_prev);
    lde_pkg::in_item_t row;
    row.address         = addr;
    row.source_line     = line;
    row.end_of_sequence = eos;
    row.restart         = rst_prev;
    rows_to_send = {rows_to_send, row};
    rows_total++;
  endtask

  task automatic note_mismatch(input string what, input lde_pkg::out_item_t want,
                               input lde_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0d: %s expected byte %02h last %b, got byte %02h last %b",
               cycle, what, want.out_byte, want.last, got.out_byte, got.last);
  endtask

  function automatic logic [63:0] rand_wide();
    return {$urandom(), $urandom()} >> $urandom_range(0, 63);
  endfunction

  // sender: one request offered at a time, held until taken
  always @(posedge clk) begin : drive_rows
    logic offering;
    if (rst_n) begin
      offering = in_push;
      if (in_push && !in_full) begin
        encode_row(in_item);
        rows_taken++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (rows_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= 12)) begin
          in_item <= rows_to_send.pop_front();
          in_push <= 1'b1;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each popped byte against the oldest prediction
  always @(posedge clk) begin : take_bytes
    lde_pkg::out_item_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (program_bytes.size() == 0) begin
          note_mismatch("unexpected byte,", '0, out_item);
        end else begin
          want = program_bytes.pop_front();
          if (out_item.out_byte !== want.out_byte || out_item.last !== want.last)
            note_mismatch("wrong byte,", want, out_item);
        end
      end
      out_pop <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 12);
    end
  end

  // long hold-off on the result side so the block backs up and stalls its input
  always @(posedge clk) begin
    if (!rst_n)
      hold_left <= 0;
    else if (cycle == HOLD_AT)
      hold_left <= HOLD_LEN;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == LIMIT) begin
      $display("line_table_delta_encoder: mismatch");
      $finish;
    end
  end

  initial begin
    logic [63:0] gen_addr;
    logic [31:0] gen_line;
    logic        gen_restart;
    logic        gen_eos;
    int          seq_left;
    int          line_step;

    // directed rows: unchanged row, leb128 length boundaries, wraps, restart
    add_row(64'd0, 32'd1, 1'b0, 1'b0);
    add_row(64'd0, 32'd1, 1'b1, 1'b0);
    add_row(64'd1, 32'd2, 1'b0, 1'b0);
    add_row(64'd128, 32'd66, 1'b0, 1'b0);
    add_row(64'd256, 32'd129, 1'b0, 1'b0);
    add_row(64'd256, 32'd65, 1'b0, 1'b0);
    add_row(64'd256, 32'd0, 1'b0, 1'b0);
    add_row('1, '1, 1'b0, 1'b0);
    add_row(64'd0, 32'h7FFF_FFFF, 1'b0, 1'b0);
    add_row(64'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_row(64'd0, 32'd1, 1'b0, 1'b1);
    add_row('1, 32'h8000_0001, 1'b1, 1'b1);
    add_row(64'h8000_0000_0000_0000, 32'd1, 1'b0, 1'b0);
    add_row(64'd5, 32'h7FFF_FFFF, 1'b0, 1'b1);
    add_row(64'd5, 32'h7FFF_FFFF, 1'b1, 1'b1);
    add_row(64'd5, 32'h7FFF_FFFF, 1'b0, 1'b0);
    add_row(64'h0000_0000_0000_3FFF, 32'h8000_0000, 1'b0, 1'b0);

    // random rows: mostly plausible sequences, some noise
    gen_addr = 64'd0;
    gen_line = 32'd1;
    seq_left = 0;
    for (int k = 0; k < RANDOM_ROWS; k++) begin
      if ($urandom_range(0, 99) < 20) begin
        gen_addr = rand_wide();
        gen_line = $urandom() >> $urandom_range(0, 31);
        add_row(gen_addr, gen_line, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        gen_restart = 1'b0;
        if (seq_left == 0) begin
          seq_left = $urandom_range(2, 12);
          gen_restart = 1'($urandom_range(0, 1));
          if (gen_restart || $urandom_range(0, 1))
            gen_addr = {32'd0, $urandom()} >> $urandom_range(0, 31);
          if (gen_restart)
            gen_line = $urandom_range(1, 300);
        end
        if ($urandom_range(0, 4) != 0)
          gen_addr = gen_addr + ($urandom_range(0, 9) == 0 ? $urandom_range(0, 100000)
                                                          : $urandom_range(1, 64));
        if ($urandom_range(0, 3) != 0) begin
          line_step = $urandom_range(0, 80) - 40;
          gen_line = gen_line + line_step;
        end
        seq_left--;
        gen_eos = (seq_left == 0);
        add_row(gen_addr, gen_line, gen_eos, gen_restart);
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (rows_taken != rows_total) @(posedge clk);
    while (program_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (mismatches == 0 && program_bytes.size() == 0) begin
      $display("line_table_delta_encoder: match");
    end else begin
      $display("line_table_delta_encoder: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lde_pkg.sv
rtl/lde_front.sv
rtl/lde_cmd_queue.sv
rtl/lde_back.sv
rtl/line_table_delta_encoder.sv
bench/testbench.sv
